// ----- hw/rtl/tcw_pkg.sv -----
`default_nettype none

package tcw_pkg;

    // Screen geometry defaults.
    localparam int COLUMNS_DEF = 80;
    localparam int ROWS_DEF    = 25;

    // Fixed field widths of the channels.
    localparam int CMD_W      = 2;
    localparam int CHAR_W     = 8;
    localparam int ATTR_W     = 8;
    localparam int RCOL_W     = 7;
    localparam int RROW_W     = 5;
    localparam int CELL_W     = 16;
    localparam int ROW_OUT_W  = 5;
    localparam int COL_OUT_W  = 7;
    localparam int ATTR_SHIFT = 8;

    localparam logic [CHAR_W-1:0] NEWLINE_CODE     = 8'd10;
    localparam logic [CHAR_W-1:0] SPACE_CODE       = 8'd32;
    localparam logic [ATTR_W-1:0] TEXT_COLOR_RESET = 8'd7;

    // Depth of the queue between the front and the back.
    localparam int QUEUE_DEPTH = 2;

    // Command codes on the input channel.
    localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_CHAR,
        OP_NEWLINE,
        OP_CLEAR,
        OP_READ
    } t_op;

    typedef struct packed {
        t_op               op;
        logic [CHAR_W-1:0] ch;
        logic              in_range;
    } t_cmd;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_SHIFT,
        S_FILL,
        S_CLEAR
    } t_state;

    function automatic logic [CELL_W-1:0] make_cell(input logic [CHAR_W-1:0] ch,
                                                    input logic [ATTR_W-1:0] attr);
        make_cell = (CELL_W'(attr) << ATTR_SHIFT) | CELL_W'(ch);
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/tcw_if.sv -----
`default_nettype none

interface tcw_in_if;
    import tcw_pkg::*;

    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  cmd;
    logic [CHAR_W-1:0] char_code;
    logic [RCOL_W-1:0] read_col;
    logic [RROW_W-1:0] read_row;

    modport source (output valid, cmd, char_code, read_col, read_row, input ready);
    modport sink   (input valid, cmd, char_code, read_col, read_row, output ready);
endinterface

interface tcw_out_if;
    import tcw_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CELL_W-1:0]    cell_data;
    logic [ROW_OUT_W-1:0] cursor_row_out;
    logic [COL_OUT_W-1:0] cursor_col_out;
    logic                 scrolled;

    modport source (output valid, cell_data, cursor_row_out, cursor_col_out, scrolled,
                    input ready);
    modport sink   (input valid, cell_data, cursor_row_out, cursor_col_out, scrolled,
                    output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/tcw_ram.sv -----
`default_nettype none

module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

`default_nettype wire

// ----- hw/rtl/tcw_fifo.sv -----
`default_nettype none

module tcw_fifo #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    input  wire logic             i_pop,
    output      logic [WIDTH-1:0] o_data,
    output      logic             o_valid,
    output      logic             o_ready
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wptr, n_wptr;
    logic [PW-1:0]    r_rptr, n_rptr;
    logic [CNTW-1:0]  r_count, n_count;

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (i_push) begin
            n_wptr = (r_wptr == PW'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (i_pop) begin
            n_rptr = (r_rptr == PW'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    assign o_data  = r_mem[r_rptr];
    assign o_valid = (r_count != '0);
    assign o_ready = (r_count != CNTW'(DEPTH));
endmodule

`default_nettype wire

// ----- hw/rtl/tcw_front.sv -----
`default_nettype none

module tcw_front #(
    parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
    parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
    tcw_in_if.sink                              i_in,
    input  wire logic                           i_queue_ready,
    output      logic                           o_push,
    output      tcw_pkg::t_cmd                  o_cmd,
    output      logic [$clog2(ROWS*COLUMNS)-1:0] o_addr
);
    import tcw_pkg::*;

    localparam int AW = $clog2(ROWS * COLUMNS);

    assign i_in.ready = i_queue_ready;
    assign o_push     = i_in.valid && i_queue_ready;

    always_comb begin
        o_cmd.ch       = i_in.char_code;
        o_cmd.in_range = ({1'b0, i_in.read_col} < 8'(COLUMNS))
                      && ({2'b00, i_in.read_row} < 7'(ROWS));
        unique case (i_in.cmd)
            CMD_PUT:   o_cmd.op = (i_in.char_code == NEWLINE_CODE) ? OP_NEWLINE : OP_CHAR;
            CMD_CLEAR: o_cmd.op = OP_CLEAR;
            CMD_READ:  o_cmd.op = OP_READ;
            default:   o_cmd.op = OP_NOP;
        endcase
    end

    // Linear cell address; only meaningful when the read lies on the screen.
    assign o_addr = AW'(AW'(i_in.read_row) * AW'(COLUMNS)) + AW'(i_in.read_col);
endmodule

`default_nettype wire

// ----- hw/rtl/tcw_back.sv -----
`default_nettype none

module tcw_back #(
    parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
    parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cmd_valid,
    input  wire tcw_pkg::t_cmd                   i_cmd,
    input  wire logic [$clog2(ROWS*COLUMNS)-1:0] i_addr,
    input  wire logic [tcw_pkg::ATTR_W-1:0]      i_text_color,
    output      logic                            o_pop,
    tcw_out_if.source                            o_out
);
    import tcw_pkg::*;

    localparam int CELL_COUNT = ROWS * COLUMNS;
    localparam int AW         = $clog2(CELL_COUNT);
    localparam int RW         = $clog2(ROWS);
    localparam int CW         = $clog2(COLUMNS);
    localparam int SHIFT_LAST = CELL_COUNT - COLUMNS - 1;
    localparam int FILL_FIRST = CELL_COUNT - COLUMNS;

    t_state            r_state, n_state;
    logic [RW-1:0]     r_row, n_row;
    logic [CW-1:0]     r_col, n_col;
    logic [AW-1:0]     r_base, n_base;
    logic [AW-1:0]     r_cnt, n_cnt;
    logic              r_pend, n_pend;
    logic [AW-1:0]     r_pend_addr, n_pend_addr;

    logic                 r_out_valid;
    logic [CELL_W-1:0]    r_out_data;
    logic [ROW_OUT_W-1:0] r_out_row;
    logic [COL_OUT_W-1:0] r_out_col;
    logic                 r_out_scrolled;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [CELL_W-1:0] ram_wdata;
    logic [AW-1:0]     ram_raddr;
    logic [CELL_W-1:0] ram_rdata;

    logic              res_load;
    logic [CELL_W-1:0] res_data;
    logic              res_scrolled;

    logic slot_free;
    logic start;
    logic last_row;
    logic last_col;

    assign slot_free = !r_out_valid || o_out.ready;
    assign start     = (r_state == S_IDLE) && i_cmd_valid && slot_free;
    assign last_row  = (r_row == RW'(ROWS - 1));
    assign last_col  = (r_col == CW'(COLUMNS - 1));

    tcw_ram #(
        .WIDTH(CELL_W),
        .DEPTH(CELL_COUNT)
    ) u_screen (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    unique case (i_cmd.op)
                        OP_READ:    n_state = i_cmd.in_range ? S_READ : S_IDLE;
                        OP_CLEAR:   n_state = S_CLEAR;
                        OP_NEWLINE: n_state = last_row ? S_SHIFT : S_IDLE;
                        OP_CHAR:    n_state = (last_col && last_row) ? S_SHIFT : S_IDLE;
                        default:    n_state = S_IDLE;
                    endcase
                end
            end
            S_READ: n_state = S_IDLE;
            S_SHIFT: begin
                if (r_cnt == AW'(SHIFT_LAST)) begin
                    n_state = S_FILL;
                end
            end
            S_FILL: begin
                if (!r_pend && r_cnt == AW'(CELL_COUNT - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_CLEAR: begin
                if (r_cnt == AW'(CELL_COUNT - 1)) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath and memory control.
    always_comb begin
        n_row        = r_row;
        n_col        = r_col;
        n_base       = r_base;
        n_cnt        = r_cnt;
        n_pend       = 1'b0;
        n_pend_addr  = r_pend_addr;
        o_pop        = 1'b0;
        res_load     = 1'b0;
        res_data     = '0;
        res_scrolled = 1'b0;
        ram_raddr    = i_addr;
        // A copied cell read in the previous cycle lands here.
        ram_we       = r_pend;
        ram_waddr    = r_pend_addr;
        ram_wdata    = ram_rdata;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_pop = 1'b1;
                    unique case (i_cmd.op) inside
                        OP_READ: begin
                            res_load = !i_cmd.in_range;
                        end
                        OP_CLEAR: begin
                            n_cnt = '0;
                        end
                        OP_CHAR, OP_NEWLINE: begin
                            if (i_cmd.op == OP_CHAR) begin
                                ram_we    = 1'b1;
                                ram_waddr = r_base + AW'(r_col);
                                ram_wdata = make_cell(i_cmd.ch, i_text_color);
                            end
                            if (i_cmd.op == OP_CHAR && !last_col) begin
                                n_col    = r_col + 1'b1;
                                res_load = 1'b1;
                            end else begin
                                n_col = '0;
                                if (last_row) begin
                                    n_cnt = '0;
                                end else begin
                                    n_row    = r_row + 1'b1;
                                    n_base   = r_base + AW'(COLUMNS);
                                    res_load = 1'b1;
                                end
                            end
                        end
                        default: begin
                            res_load = 1'b1;
                        end
                    endcase
                end
            end
            S_READ: begin
                res_load = 1'b1;
                res_data = ram_rdata;
            end
            S_SHIFT: begin
                ram_raddr   = r_cnt + AW'(COLUMNS);
                n_pend      = 1'b1;
                n_pend_addr = r_cnt;
                n_cnt       = (r_cnt == AW'(SHIFT_LAST)) ? AW'(FILL_FIRST) : r_cnt + 1'b1;
            end
            S_FILL: begin
                if (!r_pend) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_cnt;
                    ram_wdata = make_cell(SPACE_CODE, i_text_color);
                    if (r_cnt == AW'(CELL_COUNT - 1)) begin
                        res_load     = 1'b1;
                        res_scrolled = 1'b1;
                    end else begin
                        n_cnt = r_cnt + 1'b1;
                    end
                end
            end
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_cnt;
                ram_wdata = make_cell(SPACE_CODE, i_text_color);
                if (r_cnt == AW'(CELL_COUNT - 1)) begin
                    n_row    = '0;
                    n_col    = '0;
                    n_base   = '0;
                    res_load = 1'b1;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            default: begin
                n_cnt = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_row       <= '0;
            r_col       <= '0;
            r_base      <= '0;
            r_cnt       <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_row   <= n_row;
            r_col   <= n_col;
            r_base  <= n_base;
            r_cnt   <= n_cnt;
            r_pend  <= n_pend;
            if (res_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_addr <= n_pend_addr;
        if (res_load) begin
            r_out_data     <= res_data;
            r_out_row      <= ROW_OUT_W'(n_row);
            r_out_col      <= COL_OUT_W'(n_col);
            r_out_scrolled <= res_scrolled;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.cell_data      = r_out_data;
    assign o_out.cursor_row_out = r_out_row;
    assign o_out.cursor_col_out = r_out_col;
    assign o_out.scrolled       = r_out_scrolled;

    // A new command is taken only while the sequencer is idle.
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> (r_state == S_IDLE))
        else $error("command taken while the back end is busy");

    // A result never overwrites one that is still waiting.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_load |-> slot_free)
        else $error("result register overwritten");

    // Every write lands inside the screen store.
    a_write_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (ram_waddr <= AW'(CELL_COUNT - 1)))
        else $error("screen write out of range");

    // The end of a bottom-row fill reports a scroll on the last row.
    a_scroll_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FILL && n_state == S_IDLE)
        |=> (o_out.valid && o_out.scrolled && o_out.cursor_col_out == '0))
        else $error("scroll finished without a scrolled result");

    // A read that waits on the store always produces its result next cycle.
    a_read_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |=> (o_out.valid && !o_out.scrolled))
        else $error("read finished without a result");
endmodule

`default_nettype wire

// ----- hw/rtl/text_terminal_cell_writer.sv -----
`default_nettype none

// Text-mode character terminal with a ROWS x COLUMNS store of 16-bit cells
// (attribute in the high byte, character in the low byte) and a cursor. Each
// input transaction yields exactly one result transaction carrying the cursor
// after the command. Commands enter a two-entry queue, so input is taken while
// a result waits. The back end is one sequencer around a single-port-write,
// registered-read memory: an ordinary character or a newline without a scroll
// completes in its command cycle, a read waits on the registered memory read,
// a scroll runs the command cycle, one cell copied per cycle, a step for the
// last copied cell to land, then the bottom row filled, and a clear runs the
// command cycle, then one cell written per cycle. There is no clearing pass
// after reset: the store holds garbage until the first clear command, and
// software must issue that clear before any read; the block does not enforce
// it. The text color register is to be written only while the block is idle;
// the block itself does not enforce this.
module text_terminal_cell_writer #(
    parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
    parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    tcw_in_if.sink                          i_in,
    tcw_out_if.source                       o_out,
    input  wire logic                       i_cfg_we,
    input  wire logic [tcw_pkg::ATTR_W-1:0] i_cfg_data
);
    import tcw_pkg::*;

    localparam int AW      = $clog2(ROWS * COLUMNS);
    localparam int ENTRY_W = $bits(t_cmd) + AW;

    logic [ATTR_W-1:0]  r_text_color;

    logic               q_ready;
    logic               q_valid;
    logic               push;
    logic               pop;
    t_cmd               front_cmd;
    logic [AW-1:0]      front_addr;
    logic [ENTRY_W-1:0] q_data;
    t_cmd               back_cmd;
    logic [AW-1:0]      back_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_text_color <= TEXT_COLOR_RESET;
        end else if (i_cfg_we) begin
            r_text_color <= i_cfg_data;
        end
    end

    tcw_front #(
        .COLUMNS(COLUMNS),
        .ROWS   (ROWS)
    ) u_front (
        .i_in         (i_in),
        .i_queue_ready(q_ready),
        .o_push       (push),
        .o_cmd        (front_cmd),
        .o_addr       (front_addr)
    );

    tcw_fifo #(
        .WIDTH(ENTRY_W),
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_data ({front_cmd, front_addr}),
        .i_pop  (pop),
        .o_data (q_data),
        .o_valid(q_valid),
        .o_ready(q_ready)
    );

    assign back_cmd  = t_cmd'(q_data[ENTRY_W-1:AW]);
    assign back_addr = q_data[AW-1:0];

    tcw_back #(
        .COLUMNS(COLUMNS),
        .ROWS   (ROWS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_valid),
        .i_cmd       (back_cmd),
        .i_addr      (back_addr),
        .i_text_color(r_text_color),
        .o_pop       (pop),
        .o_out       (o_out)
    );
endmodule

`default_nettype wire

// ----- bench/text_terminal_cell_writer_tb.sv -----
`timescale 1ns / 100ps

module text_terminal_cell_writer_tb;
    import tcw_pkg::*;

    localparam int CLK_HALF  = 4;
    localparam int SCR_COLS  = COLUMNS_DEF;
    localparam int SCR_ROWS  = ROWS_DEF;
    localparam int SCR_CELLS = SCR_COLS * SCR_ROWS;
    localparam int RAND_SEGMENTS = 6;
    localparam int SEGMENT_ITEMS = 280;
    localparam int DIR_COUNT = 22;

    // The package names no code for the spare command value.
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [CHAR_W-1:0] ch;
        logic [RCOL_W-1:0] col;
        logic [RROW_W-1:0] row;
    } t_cmd_item;

    typedef struct packed {
        logic [CELL_W-1:0]    data;
        logic [ROW_OUT_W-1:0] row;
        logic [COL_OUT_W-1:0] col;
        logic                 scrolled;
    } t_term_result;

    typedef struct packed {
        t_cmd_item    item;
        logic         typed;
        t_term_result want;
    } t_dir_vec;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [ATTR_W-1:0] i_cfg_data;

    tcw_in_if  cmd_if ();
    tcw_out_if res_if ();

    text_terminal_cell_writer DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (cmd_if),
        .o_out      (res_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data)
    );

    // Shadow copy of the terminal.
    logic [CELL_W-1:0] screen_model [SCR_CELLS];
    int                cur_row;
    int                cur_col;
    logic [ATTR_W-1:0] text_color;
    bit                screen_cleared;

    t_term_result expected_q [$];

    int src_idle_pct;
    int snk_idle_pct;
    int hold_cycles;
    int n_errors;
    int n_items;
    int n_results;
    int n_scrolls;
    int n_clears;
    int n_reads;
    int n_colors;

    // Directed vectors; rows marked typed carry their expected result inline.
    t_dir_vec dir_table [DIR_COUNT] = '{
        '{'{CMD_READ,   8'h00,        7'd80,  5'd0},  1'b1, '{16'h0000, 5'd0, 7'd0, 1'b0}},
        '{'{CMD_UNUSED, 8'hFF,        7'd127, 5'd31}, 1'b1, '{16'h0000, 5'd0, 7'd0, 1'b0}},
        '{'{CMD_CLEAR,  8'h00,        7'd0,   5'd0},  1'b1, '{16'h0000, 5'd0, 7'd0, 1'b0}},
        '{'{CMD_READ,   8'h00,        7'd0,   5'd0},  1'b1, '{16'h0720, 5'd0, 7'd0, 1'b0}},
        '{'{CMD_READ,   8'h00,        7'd79,  5'd24}, 1'b1, '{16'h0720, 5'd0, 7'd0, 1'b0}},
        '{'{CMD_PUT,    8'h41,        7'd0,   5'd0},  1'b1, '{16'h0000, 5'd0, 7'd1, 1'b0}},
        '{'{CMD_PUT,    8'hFF,        7'd127, 5'd31}, 1'b1, '{16'h0000, 5'd0, 7'd2, 1'b0}},
        '{'{CMD_PUT,    8'h00,        7'd0,   5'd0},  1'b1, '{16'h0000, 5'd0, 7'd3, 1'b0}},
        '{'{CMD_READ,   8'h00,        7'd0,   5'd0},  1'b1, '{16'h0741, 5'd0, 7'd3, 1'b0}},
        '{'{CMD_READ,   8'h00,        7'd1,   5'd0},  1'b1, '{16'h07FF, 5'd0, 7'd3, 1'b0}},
        '{'{CMD_READ,   8'h00,        7'd2,   5'd0},  1'b1, '{16'h0700, 5'd0, 7'd3, 1'b0}},
        '{'{CMD_PUT,    NEWLINE_CODE, 7'd0,   5'd0},  1'b1, '{16'h0000, 5'd1, 7'd0, 1'b0}},
        '{'{CMD_READ,   8'h00,        7'd127, 5'd0},  1'b1, '{16'h0000, 5'd1, 7'd0, 1'b0}},
        '{'{CMD_READ,   8'h00,        7'd0,   5'd31}, 1'b1, '{16'h0000, 5'd1, 7'd0, 1'b0}},
        '{'{CMD_READ,   8'h00,        7'd80,  5'd25}, 1'b1, '{16'h0000, 5'd1, 7'd0, 1'b0}},
        '{'{CMD_UNUSED, NEWLINE_CODE, 7'd5,   5'd5},  1'b1, '{16'h0000, 5'd1, 7'd0, 1'b0}},
        '{'{CMD_PUT,    SPACE_CODE,   7'd0,   5'd0},  1'b1, '{16'h0000, 5'd1, 7'd1, 1'b0}},
        '{'{CMD_READ,   8'h00,        7'd3,   5'd0},  1'b1, '{16'h0720, 5'd1, 7'd1, 1'b0}},
        '{'{CMD_READ,   8'h00,        7'd0,   5'd1},  1'b1, '{16'h0720, 5'd1, 7'd1, 1'b0}},
        '{'{CMD_PUT,    8'h7E,        7'd64,  5'd16}, 1'b0, '0},
        '{'{CMD_READ,   8'h00,        7'd1,   5'd1},  1'b0, '0},
        '{'{CMD_READ,   8'h00,        7'd40,  5'd12}, 1'b0, '0}
    };

    always #CLK_HALF i_clk = ~i_clk;

    function automatic bit advance_row();
        cur_col = 0;
        cur_row++;
        if (cur_row >= SCR_ROWS) begin
            for (int i = 0; i < SCR_CELLS - SCR_COLS; i++) begin
                screen_model[i] = screen_model[i + SCR_COLS];
            end
            for (int i = SCR_CELLS - SCR_COLS; i < SCR_CELLS; i++) begin
                screen_model[i] = {text_color, SPACE_CODE};
            end
            cur_row = SCR_ROWS - 1;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic t_term_result apply_command(input t_cmd_item it);
        t_term_result r;
        r = '0;
        case (it.cmd)
            CMD_PUT: begin
                if (it.ch == NEWLINE_CODE) begin
                    r.scrolled = advance_row();
                end else begin
                    screen_model[cur_row * SCR_COLS + cur_col] = {text_color, it.ch};
                    cur_col++;
                    if (cur_col >= SCR_COLS) begin
                        r.scrolled = advance_row();
                    end
                end
            end
            CMD_CLEAR: begin
                for (int i = 0; i < SCR_CELLS; i++) begin
                    screen_model[i] = {text_color, SPACE_CODE};
                end
                cur_row = 0;
                cur_col = 0;
                screen_cleared = 1'b1;
            end
            CMD_READ: begin
                if (int'(it.col) < SCR_COLS && int'(it.row) < SCR_ROWS) begin
                    r.data = screen_model[int'(it.row) * SCR_COLS + int'(it.col)];
                end
            end
            default: ;
        endcase
        r.row = ROW_OUT_W'(cur_row);
        r.col = COL_OUT_W'(cur_col);
        return r;
    endfunction

    // Mostly text with occasional newlines and read-back near the cursor;
    // clears are rare so that the cursor reaches the bottom and scrolls.
    function automatic t_cmd_item random_command();
        t_cmd_item it;
        int pick;
        pick = $urandom_range(999);
        it.ch  = CHAR_W'($urandom_range(255));
        it.col = RCOL_W'($urandom_range(127));
        it.row = RROW_W'($urandom_range(31));
        if (pick < 640) begin
            it.cmd = CMD_PUT;
            if ($urandom_range(99) < 5) begin
                it.ch = NEWLINE_CODE;
            end
        end else if (pick < 920) begin
            it.cmd = CMD_READ;
            if (!screen_cleared || $urandom_range(99) < 10) begin
                if ($urandom_range(1) == 0) begin
                    it.col = RCOL_W'($urandom_range(127, SCR_COLS));
                end else begin
                    it.row = RROW_W'($urandom_range(31, SCR_ROWS));
                end
            end else begin
                it.col = RCOL_W'($urandom_range(SCR_COLS - 1));
                if ($urandom_range(1) == 0) begin
                    it.row = RROW_W'(cur_row);
                end else begin
                    it.row = RROW_W'($urandom_range(SCR_ROWS - 1));
                end
            end
        end else if (pick < 925) begin
            it.cmd = CMD_CLEAR;
        end else begin
            it.cmd = CMD_UNUSED;
        end
        return it;
    endfunction

    task automatic send_command(input t_cmd_item it, input logic typed,
                                input t_term_result want);
        t_term_result pred;
        while ($urandom_range(99) < src_idle_pct) begin
            cmd_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        cmd_if.valid     <= 1'b1;
        cmd_if.cmd       <= it.cmd;
        cmd_if.char_code <= it.ch;
        cmd_if.read_col  <= it.col;
        cmd_if.read_row  <= it.row;
        @(posedge i_clk);
        while (!cmd_if.ready) begin
            @(posedge i_clk);
        end
        pred = apply_command(it);
        expected_q.push_back(typed ? want : pred);
        n_items++;
        n_scrolls += pred.scrolled;
        if (it.cmd == CMD_CLEAR) begin
            n_clears++;
        end
        if (it.cmd == CMD_READ && int'(it.col) < SCR_COLS && int'(it.row) < SCR_ROWS) begin
            n_reads++;
        end
    endtask

    task automatic drain_results();
        cmd_if.valid <= 1'b0;
        while (expected_q.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic set_color(input logic [ATTR_W-1:0] value);
        i_cfg_data <= value;
        i_cfg_we   <= 1'b1;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        text_color = value;
        n_colors++;
    endtask

    // Result side: random back-pressure, a counted hold-off, and the checker.
    always @(posedge i_clk) begin : result_side
        t_term_result got;
        t_term_result want;
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                got.data     = res_if.cell_data;
                got.row      = res_if.cursor_row_out;
                got.col      = res_if.cursor_col_out;
                got.scrolled = res_if.scrolled;
                n_results++;
                if (expected_q.size() == 0) begin
                    n_errors++;
                    $display("%0t: unexpected result data=%h row=%0d col=%0d scrolled=%0b",
                             $time, got.data, got.row, got.col, got.scrolled);
                end else begin
                    want = expected_q.pop_front();
                    if (got !== want) begin
                        n_errors++;
                        $display("%0t: mismatch expected data=%h row=%0d col=%0d scrolled=%0b",
                                 $time, want.data, want.row, want.col, want.scrolled);
                        $display("%0t:          actual   data=%h row=%0d col=%0d scrolled=%0b",
                                 $time, got.data, got.row, got.col, got.scrolled);
                    end
                end
            end
            if (hold_cycles > 0) begin
                hold_cycles--;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= ($urandom_range(99) >= snk_idle_pct);
            end
        end
    end

    initial begin
        #10_000_000;
        $display("** text_terminal_cell_writer: FAILED **");
        $finish;
    end

    initial begin
        i_clk            = 1'b0;
        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_data       = '0;
        cmd_if.valid     = 1'b0;
        cmd_if.cmd       = CMD_PUT;
        cmd_if.char_code = '0;
        cmd_if.read_col  = '0;
        cmd_if.read_row  = '0;
        res_if.ready     = 1'b0;
        cur_row          = 0;
        cur_col          = 0;
        text_color       = TEXT_COLOR_RESET;
        screen_cleared   = 1'b0;
        hold_cycles      = 0;
        n_errors         = 0;
        n_items          = 0;
        n_results        = 0;
        n_scrolls        = 0;
        n_clears         = 0;
        n_reads          = 0;
        n_colors         = 1;
        src_idle_pct     = 6;
        snk_idle_pct     = 82;
        for (int i = 0; i < SCR_CELLS; i++) begin
            screen_model[i] = '0;
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed vectors run under the reset text color.
        for (int i = 0; i < DIR_COUNT; i++) begin
            send_command(dir_table[i].item, dir_table[i].typed, dir_table[i].want);
        end

        // Hold the result side off long enough for the input to back up,
        // then push the cursor to the bottom so that newlines scroll.
        hold_cycles = 400;
        for (int i = 0; i < 16; i++) begin
            send_command('{CMD_PUT, CHAR_W'($urandom_range(126, 33)), 7'd0, 5'd0}, 1'b0, '0);
        end
        for (int i = 0; i < SCR_ROWS + 4; i++) begin
            send_command('{CMD_PUT, NEWLINE_CODE, 7'd0, 5'd0}, 1'b0, '0);
        end
        drain_results();

        for (int seg = 0; seg < RAND_SEGMENTS; seg++) begin
            src_idle_pct = (seg < 2) ? 6 : (seg < 4) ? 82 : 0;
            snk_idle_pct = (seg < 2) ? 82 : (seg < 4) ? 6 : 0;
            case (seg)
                0: set_color(8'hFF);
                1: set_color(8'h00);
                2: set_color(8'h1E);
                4: set_color(8'hF0);
                default: set_color(ATTR_W'($urandom_range(255)));
            endcase
            repeat (SEGMENT_ITEMS) begin
                send_command(random_command(), 1'b0, '0);
            end
            drain_results();
        end

        // A scroll is the longest operation; let any stray result show up.
        repeat (2 * SCR_CELLS) @(posedge i_clk);

        $display("Run covered %0d commands: %0d in-range reads, %0d clears, %0d scrolls,",
                 n_items, n_reads, n_clears, n_scrolls);
        $display("%0d results checked under %0d text colors, %0d mismatches.",
                 n_results, n_colors, n_errors);
        if (n_errors == 0 && expected_q.size() == 0) begin
            $display("** text_terminal_cell_writer: PASSED **");
        end else begin
            $display("** text_terminal_cell_writer: FAILED **");
        end
        $finish;
    end

endmodule

// ----- text_terminal_cell_writer.f -----
hw/rtl/tcw_pkg.sv
hw/rtl/tcw_if.sv
hw/rtl/tcw_ram.sv
hw/rtl/tcw_fifo.sv
hw/rtl/tcw_front.sv
hw/rtl/tcw_back.sv
hw/rtl/text_terminal_cell_writer.sv
bench/text_terminal_cell_writer_tb.sv
